// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge while reset is released.
`define MBRF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising edge, reset cycles included.
`define MBRF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== rtl/mbrf_pkg.sv =====
// Package: shared types, codes and the CRC-16 byte step for the request framer.
`timescale 1ns / 1ps

package mbrf_pkg;

    // Item kinds on the input channel
    localparam logic ACT_HEADER  = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    // Function select codes
    localparam logic [2:0] FSEL_RD_COILS  = 3'd0;
    localparam logic [2:0] FSEL_RD_DISC   = 3'd1;
    localparam logic [2:0] FSEL_RD_HOLD   = 3'd2;
    localparam logic [2:0] FSEL_RD_INPUT  = 3'd3;
    localparam logic [2:0] FSEL_WR_COILS  = 3'd4;
    localparam logic [2:0] FSEL_WR_REGS   = 3'd5;

    // Modbus function codes sent on the wire
    localparam logic [7:0] FC_RD_COILS = 8'h01;
    localparam logic [7:0] FC_RD_DISC  = 8'h02;
    localparam logic [7:0] FC_RD_HOLD  = 8'h03;
    localparam logic [7:0] FC_RD_INPUT = 8'h04;
    localparam logic [7:0] FC_WR_COILS = 8'h0F;
    localparam logic [7:0] FC_WR_REGS  = 8'h10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int JOB_BYTES = 7;

    // One unit of work for the byte serializer
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] data;   // data bytes, index 0 goes first
        logic [2:0]                n_data; // number of data bytes, 1..7
        logic                      crc;    // append the CRC after the data
        logic                      start;  // first job of a frame: restart the CRC
    } t_job;

    // Fold one byte into the reflected Modbus CRC-16
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/modbus_rtu_request_framer.sv =====
// Top level: Modbus RTU request framer, classifier and byte serializer joined by a job queue.
`timescale 1ns / 1ps

// Modbus RTU request framer. Each input transfer is either a request header
// or one payload element of an open write request; each output transfer is
// one frame byte in wire order, with o_frame_end set on the high CRC byte.
// The serializer sends one byte per cycle while the output is not stalled.
// An item produces 8 bytes for a read header, 7 for a write header (9 when
// the byte count is zero and the CRC follows at once), 2 for a register
// word, 1 for a coil byte, plus 2 for the CRC on the element that closes
// the frame. Headers with an unknown function and payload with no frame
// open are accepted and produce nothing. The front end classifies an item in
// the cycle it is accepted and posts a job into a two-entry queue; it keeps
// accepting while the queue has room, so the serializer and the output
// register run ahead independently. A job passes through the queue, the
// serializer job register and the output register before its first byte
// appears. The input stalls only when the queue is full, and the output
// holds its byte while the downstream stalls.
module modbus_rtu_request_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [7:0]  i_slave_id,
    input  logic [2:0]  i_func_select,
    input  logic [15:0] i_start_address,
    input  logic [15:0] i_quantity,
    input  logic [15:0] i_payload,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_tx_byte,
    output logic        o_frame_end
);
    import mbrf_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_job push_job;
    t_job head_job;

    // Classify items and track the open write frame
    mbrf_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_slave_id      (i_slave_id),
        .i_func_select   (i_func_select),
        .i_start_address (i_start_address),
        .i_quantity      (i_quantity),
        .i_payload       (i_payload),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_job           (push_job)
    );

    // Hold jobs so either side can stall on its own
    mbrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job),
        .i_pop   (q_pop)
    );

    // Send bytes, fold the CRC and append it at frame end
    mbrf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_job     (head_job),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_tx_byte   (o_tx_byte),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== rtl/mbrf_queue.sv =====
// Two-entry job queue between the classifier and the byte serializer.
`timescale 1ns / 1ps

module mbrf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mbrf_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output mbrf_pkg::t_job o_job,
    input  logic           i_pop
);
    import mbrf_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== rtl/mbrf_front.sv =====
// Front end: accepts input items, tracks the open write frame, builds serializer jobs.
`timescale 1ns / 1ps

module mbrf_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_action,
    input  logic [7:0]     i_slave_id,
    input  logic [2:0]     i_func_select,
    input  logic [15:0]    i_start_address,
    input  logic [15:0]    i_quantity,
    input  logic [15:0]    i_payload,
    input  logic           i_q_full,
    output logic           o_push,
    output mbrf_pkg::t_job o_job
);
    import mbrf_pkg::*;

    logic        r_frame_open;
    logic [7:0]  r_left;
    logic        r_wr_regs;
    logic        n_frame_open;
    logic [7:0]  n_left;
    logic        n_wr_regs;

    logic        accept;
    logic [7:0]  fc;
    logic        is_read;
    logic        fsel_ok;
    logic [16:0] qty_plus7;
    logic [7:0]  count;
    logic [7:0]  left_next;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign qty_plus7  = {1'b0, i_quantity} + 17'd7;

    // Decode the function select
    always_comb begin
        fc      = FC_RD_COILS;
        is_read = 1'b0;
        fsel_ok = 1'b1;
        unique case (i_func_select) inside
            FSEL_RD_COILS: begin fc = FC_RD_COILS; is_read = 1'b1; end
            FSEL_RD_DISC:  begin fc = FC_RD_DISC;  is_read = 1'b1; end
            FSEL_RD_HOLD:  begin fc = FC_RD_HOLD;  is_read = 1'b1; end
            FSEL_RD_INPUT: begin fc = FC_RD_INPUT; is_read = 1'b1; end
            FSEL_WR_COILS: fc = FC_WR_COILS;
            FSEL_WR_REGS:  fc = FC_WR_REGS;
            default:       fsel_ok = 1'b0;
        endcase
    end

    // Byte count, truncated to eight bits
    assign count = (i_func_select == FSEL_WR_REGS) ? {i_quantity[6:0], 1'b0}
                                                   : qty_plus7[10:3];

    assign left_next = r_wr_regs ? ((r_left >= 8'd2) ? (r_left - 8'd2) : 8'd0)
                                 : (r_left - 8'd1);

    always_comb begin
        n_frame_open = r_frame_open;
        n_left       = r_left;
        n_wr_regs    = r_wr_regs;
        o_push       = 1'b0;
        o_job        = '0;
        if (accept) begin
            if (i_action == ACT_HEADER) begin
                if (fsel_ok) begin
                    o_push        = 1'b1;
                    o_job.start   = 1'b1;
                    o_job.data[0] = i_slave_id;
                    o_job.data[1] = fc;
                    o_job.data[2] = i_start_address[15:8];
                    o_job.data[3] = i_start_address[7:0];
                    o_job.data[4] = i_quantity[15:8];
                    o_job.data[5] = i_quantity[7:0];
                    n_frame_open  = 1'b0;
                    n_left        = 8'd0;
                    n_wr_regs     = 1'b0;
                    if (is_read) begin
                        o_job.n_data = 3'd6;
                        o_job.crc    = 1'b1;
                    end else begin
                        o_job.data[6] = count;
                        o_job.n_data  = 3'd7;
                        if (count == 8'd0) begin
                            o_job.crc = 1'b1;
                        end else begin
                            n_frame_open = 1'b1;
                            n_left       = count;
                            n_wr_regs    = (i_func_select == FSEL_WR_REGS);
                        end
                    end
                end
            end else if (r_frame_open) begin
                o_push = 1'b1;
                if (r_wr_regs) begin
                    o_job.data[0] = i_payload[15:8];
                    o_job.data[1] = i_payload[7:0];
                    o_job.n_data  = 3'd2;
                end else begin
                    o_job.data[0] = i_payload[7:0];
                    o_job.n_data  = 3'd1;
                end
                n_left = left_next;
                if (left_next == 8'd0) begin
                    // close the frame
                    o_job.crc    = 1'b1;
                    n_frame_open = 1'b0;
                    n_wr_regs    = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_left       <= 8'd0;
            r_wr_regs    <= 1'b0;
        end else begin
            r_frame_open <= n_frame_open;
            r_left       <= n_left;
            r_wr_regs    <= n_wr_regs;
        end
    end

endmodule

// ===== rtl/mbrf_back.sv =====
// Back end: serializes job bytes, runs the CRC and appends it, drives the output register.
`timescale 1ns / 1ps

module mbrf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  mbrf_pkg::t_job i_q_job,
    output logic           o_q_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_tx_byte,
    output logic           o_frame_end
);
    import mbrf_pkg::*;

    t_job        r_job;
    logic        r_active;
    logic [3:0]  r_idx;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_tx_byte;
    logic        r_frame_end;

    t_job        n_job;
    logic        n_active;
    logic [3:0]  n_idx;
    logic [15:0] n_crc;
    logic        n_out_valid;
    logic [7:0]  n_tx_byte;
    logic        n_frame_end;

    logic [3:0]  cur_n;
    logic [3:0]  last_idx;
    logic        in_data;
    logic        crc_lo;
    logic [7:0]  data_byte;
    logic [7:0]  emit_byte;
    logic        emit_end;
    logic        adv;
    logic        step;
    logic        last_now;
    logic        load;

    always_comb begin
        cur_n     = {1'b0, r_job.n_data};
        in_data   = (r_idx < cur_n);
        crc_lo    = (r_idx == cur_n);
        data_byte = r_job.data[r_idx[2:0]];
        emit_byte = in_data ? data_byte : (crc_lo ? r_crc[7:0] : r_crc[15:8]);
        emit_end  = !in_data && !crc_lo;
        last_idx  = r_job.crc ? (cur_n + 4'd1) : (cur_n - 4'd1);
        last_now  = (r_idx == last_idx);
        adv       = !r_out_valid || !i_out_stall;
        step      = r_active && adv;
        load      = i_q_valid && (!r_active || (step && last_now));
    end

    always_comb begin
        n_job       = r_job;
        n_active    = r_active;
        n_idx       = r_idx;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        n_tx_byte   = r_tx_byte;
        n_frame_end = r_frame_end;
        if (adv) begin
            n_out_valid = step;
            n_tx_byte   = emit_byte;
            n_frame_end = emit_end;
        end
        if (step) begin
            n_idx = r_idx + 4'd1;
            if (in_data) begin
                n_crc = crc16_byte(r_crc, data_byte);
            end else if (emit_end) begin
                n_crc = CRC_INIT;
            end
            if (last_now) begin
                n_active = 1'b0;
            end
        end
        if (load) begin
            n_job    = i_q_job;
            n_active = 1'b1;
            n_idx    = 4'd0;
            if (i_q_job.start) begin
                // a new frame drops whatever was open before
                n_crc = CRC_INIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= 4'd0;
            r_crc       <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_idx       <= n_idx;
            r_crc       <= n_crc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job       <= n_job;
        r_tx_byte   <= n_tx_byte;
        r_frame_end <= n_frame_end;
    end

    assign o_q_pop     = load;
    assign o_out_valid = r_out_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_frame_end = r_frame_end;

endmodule

// ===== rtl/mbrf_checker.sv =====
// Port-level checker for the request framer and its bind to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mbrf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_tx_byte,
    input logic        o_frame_end
);

    // A stalled output byte stays put
    property p_out_hold;
        o_out_valid && i_out_stall
            |=> o_out_valid && $stable(o_tx_byte) && $stable(o_frame_end);
    endproperty

    // Reset leaves no byte pending and the input open
    property p_reset_idle;
        !i_rst_n |=> !o_out_valid && !o_in_stall;
    endproperty

    // The input only fills up after a transfer into it
    property p_stall_cause;
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall);
    endproperty

    // No byte appears the cycle after reset without a queued job
    property p_no_early_out;
        $past(!i_rst_n) |-> !o_out_valid;
    endproperty

    `MBRF_ASSERT(a_out_hold, i_clk, i_rst_n, p_out_hold, "stalled output changed")
    `MBRF_ASSERT_ALWAYS(a_reset_idle, i_clk, p_reset_idle, "not idle after reset")
    `MBRF_ASSERT(a_stall_cause, i_clk, i_rst_n, p_stall_cause, "input stall rose without a transfer")
    `MBRF_ASSERT(a_no_early_out, i_clk, i_rst_n, p_no_early_out, "output valid straight out of reset")

endmodule

bind modbus_rtu_request_framer mbrf_checker u_mbrf_checker (.*);

// ===== bench/modbus_rtu_request_framer_tb.sv =====
// Self-checking testbench for the Modbus RTU request framer: directed table, random frames.
`timescale 1ns / 1ps

// Each input transfer goes through a predictor before it is driven. The
// predictor keeps its own copy of the framer state and queues the frame
// bytes that the transfer must produce. The output monitor pops the oldest
// queued byte on every output transfer and compares both fields.
// The stimulus has two parts:
//   - a directed table: field extremes, every function, empty writes where
//     the byte count wraps to zero, a header that abandons an open frame,
//     unknown functions and stray payload. Rows marked silent carry their
//     expectation in the table itself: no bytes at all.
//   - random request sequences. Most of them are well-formed frames with
//     random content. The rest is noise: stray payload, unknown functions
//     and frames cut short by the next header.
// Idle pressure moves through three phases: a busy sender with a stalling
// receiver, then the reverse, then no idling on either side.
module modbus_rtu_request_framer_tb;

    import mbrf_pkg::*;

    // The function select field has two codes with no meaning
    localparam logic [2:0] FSEL_RSVD_A = 3'd6;
    localparam logic [2:0] FSEL_RSVD_B = 3'd7;

    localparam int RANDOM_ITEMS = 370;
    localparam int DRAIN_CYCLES = 16;    // spare time after the last expected byte for stray extra bytes
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on either channel

    typedef struct packed {
        logic        action;
        logic [7:0]  slave;
        logic [2:0]  fsel;
        logic [15:0] addr;
        logic [15:0] qty;
        logic [15:0] pay;
    } t_req_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_end;
    } t_wire_byte;

    // One row of the directed table; silent rows must produce no bytes
    typedef struct packed {
        logic        silent;
        logic        action;
        logic [7:0]  slave;
        logic [2:0]  fsel;
        logic [15:0] addr;
        logic [15:0] qty;
        logic [15:0] pay;
    } t_plan_row;

    localparam int PLAN_ROWS = 26;

    t_plan_row directed_plan [0:PLAN_ROWS-1] = '{
        // stray payload straight after reset
        '{1'b1, ACT_PAYLOAD, 8'h00, FSEL_RD_COILS, 16'h0000, 16'h0000, 16'hFFFF},
        // unknown functions: dropped without a byte
        '{1'b1, ACT_HEADER,  8'h5A, FSEL_RSVD_A,   16'h0102, 16'h0003, 16'h0000},
        '{1'b1, ACT_HEADER,  8'hFF, FSEL_RSVD_B,   16'hFFFF, 16'hFFFF, 16'hFFFF},
        // every read function, field extremes
        '{1'b0, ACT_HEADER,  8'hFF, FSEL_RD_COILS, 16'hFFFF, 16'hFFFF, 16'h0000},
        '{1'b0, ACT_HEADER,  8'h00, FSEL_RD_DISC,  16'h0000, 16'h0000, 16'hFFFF},
        '{1'b0, ACT_HEADER,  8'h01, FSEL_RD_HOLD,  16'h1234, 16'h007D, 16'h0000},
        '{1'b0, ACT_HEADER,  8'hF7, FSEL_RD_INPUT, 16'hA55A, 16'h0001, 16'h0000},
        // empty writes: zero count, and counts that wrap to zero
        '{1'b0, ACT_HEADER,  8'h11, FSEL_WR_COILS, 16'h0013, 16'h0000, 16'h0000},
        '{1'b0, ACT_HEADER,  8'h22, FSEL_WR_REGS,  16'h0100, 16'h0080, 16'h0000},
        '{1'b0, ACT_HEADER,  8'h33, FSEL_WR_COILS, 16'hFFFF, 16'hFFFF, 16'h0000},
        // two-register write, closed by its second word
        '{1'b0, ACT_HEADER,  8'h11, FSEL_WR_REGS,  16'h0001, 16'h0002, 16'h0000},
        '{1'b0, ACT_PAYLOAD, 8'h00, FSEL_RD_COILS, 16'h0000, 16'h0000, 16'hFFFF},
        '{1'b0, ACT_PAYLOAD, 8'h00, FSEL_RD_COILS, 16'h0000, 16'h0000, 16'h0000},
        '{1'b1, ACT_PAYLOAD, 8'h00, FSEL_RD_COILS, 16'h0000, 16'h0000, 16'hBEEF},
        // nine coils: two bytes, upper payload bits dropped
        '{1'b0, ACT_HEADER,  8'h44, FSEL_WR_COILS, 16'h0020, 16'h0009, 16'h0000},
        // unknown function while a frame is open leaves it open
        '{1'b1, ACT_HEADER,  8'h77, FSEL_RSVD_B,   16'h0000, 16'h0000, 16'h0000},
        '{1'b0, ACT_PAYLOAD, 8'h00, FSEL_RD_COILS, 16'h0000, 16'h0000, 16'hFFAA},
        '{1'b0, ACT_PAYLOAD, 8'h00, FSEL_RD_COILS, 16'h0000, 16'h0000, 16'h0055},
        // three-register write abandoned by a read header
        '{1'b0, ACT_HEADER,  8'h55, FSEL_WR_REGS,  16'h8000, 16'h0003, 16'h0000},
        '{1'b0, ACT_PAYLOAD, 8'h00, FSEL_RD_COILS, 16'h0000, 16'h0000, 16'h8001},
        '{1'b0, ACT_HEADER,  8'h66, FSEL_RD_HOLD,  16'h0040, 16'h0010, 16'h0000},
        '{1'b1, ACT_PAYLOAD, 8'h00, FSEL_RD_COILS, 16'h0000, 16'h0000, 16'h1111},
        // register count 129: byte count wraps to two
        '{1'b0, ACT_HEADER,  8'h88, FSEL_WR_REGS,  16'h7FFF, 16'h0081, 16'h0000},
        '{1'b0, ACT_PAYLOAD, 8'h00, FSEL_RD_COILS, 16'h0000, 16'h0000, 16'h7FFE},
        // single coil byte
        '{1'b0, ACT_HEADER,  8'h99, FSEL_WR_COILS, 16'h00FF, 16'h0001, 16'h0000},
        '{1'b0, ACT_PAYLOAD, 8'h00, FSEL_RD_COILS, 16'h0000, 16'h0000, 16'h1234}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_action;
    logic [7:0]  i_slave_id;
    logic [2:0]  i_func_select;
    logic [15:0] i_start_address;
    logic [15:0] i_quantity;
    logic [15:0] i_payload;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_tx_byte;
    logic        o_frame_end;

    // Predictor state
    logic [15:0] crc_run;
    logic [7:0]  bytes_owed;
    logic        frame_open;
    logic        word_mode;

    t_wire_byte  tx_expect [$];  // frame bytes still to arrive, oldest first

    int unsigned send_idle_pct = 17;
    int unsigned recv_idle_pct = 69;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;

    modbus_rtu_request_framer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_slave_id      (i_slave_id),
        .i_func_select   (i_func_select),
        .i_start_address (i_start_address),
        .i_quantity      (i_quantity),
        .i_payload       (i_payload),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_tx_byte       (o_tx_byte),
        .o_frame_end     (o_frame_end)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shift one byte into the reflected CRC-16, one data bit at a time
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int k = 0; k < 8; k++) begin
            fb  = acc[0] ^ data[k];
            acc = acc >> 1;
            if (fb) begin
                acc = acc ^ CRC_POLY;
            end
        end
        return acc;
    endfunction

    function automatic void queue_data_byte(input logic [7:0] b);
        crc_run = crc_fold(crc_run, b);
        tx_expect.push_back('{tx_byte: b, frame_end: 1'b0});
    endfunction

    // Append the CRC low byte first and close the frame
    function automatic void queue_crc_close();
        tx_expect.push_back('{tx_byte: crc_run[7:0], frame_end: 1'b0});
        tx_expect.push_back('{tx_byte: crc_run[15:8], frame_end: 1'b1});
        crc_run    = CRC_INIT;
        bytes_owed = 8'd0;
        frame_open = 1'b0;
        word_mode  = 1'b0;
    endfunction

    // Queue the bytes one item causes; return how many
    function automatic int predict_frame_bytes(input t_req_item it);
        int          depth;
        logic [7:0]  fc;
        logic [7:0]  count;
        logic [16:0] coil_sum;
        depth = tx_expect.size();
        if (it.action == ACT_HEADER) begin
            case (it.fsel)
                FSEL_RD_COILS: fc = FC_RD_COILS;
                FSEL_RD_DISC:  fc = FC_RD_DISC;
                FSEL_RD_HOLD:  fc = FC_RD_HOLD;
                FSEL_RD_INPUT: fc = FC_RD_INPUT;
                FSEL_WR_COILS: fc = FC_WR_COILS;
                FSEL_WR_REGS:  fc = FC_WR_REGS;
                default:       return 0;
            endcase
            // a new header drops whatever frame was open
            crc_run    = CRC_INIT;
            bytes_owed = 8'd0;
            frame_open = 1'b0;
            word_mode  = 1'b0;
            queue_data_byte(it.slave);
            queue_data_byte(fc);
            queue_data_byte(it.addr[15:8]);
            queue_data_byte(it.addr[7:0]);
            queue_data_byte(it.qty[15:8]);
            queue_data_byte(it.qty[7:0]);
            if (it.fsel != FSEL_WR_COILS && it.fsel != FSEL_WR_REGS) begin
                queue_crc_close();
            end else begin
                coil_sum = {1'b0, it.qty} + 17'd7;
                count = (it.fsel == FSEL_WR_REGS) ? {it.qty[6:0], 1'b0} : coil_sum[10:3];
                queue_data_byte(count);
                if (count == 8'd0) begin
                    queue_crc_close();
                end else begin
                    frame_open = 1'b1;
                    bytes_owed = count;
                    word_mode  = (it.fsel == FSEL_WR_REGS);
                end
            end
        end else if (frame_open) begin
            if (word_mode) begin
                queue_data_byte(it.pay[15:8]);
                queue_data_byte(it.pay[7:0]);
                bytes_owed = (bytes_owed >= 8'd2) ? bytes_owed - 8'd2 : 8'd0;
            end else begin
                queue_data_byte(it.pay[7:0]);
                bytes_owed = bytes_owed - 8'd1;
            end
            if (bytes_owed == 8'd0) begin
                queue_crc_close();
            end
        end
        return tx_expect.size() - depth;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_wire_byte(input logic [7:0] b, input logic fe);
        t_wire_byte want;
        if (tx_expect.size() == 0) begin
            report_mismatch($sformatf("byte %02h (frame_end %0b) with nothing expected", b, fe));
            return;
        end
        want = tx_expect.pop_front();
        if (b !== want.tx_byte) begin
            report_mismatch($sformatf("tx_byte %02h, expected %02h", b, want.tx_byte));
        end
        if (fe !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %0b, expected %0b on byte %02h",
                                      fe, want.frame_end, want.tx_byte));
        end
    endtask

    // Predict, then drive one item and hold it until the transfer happens.
    // Valid stays high into the next item unless the sender idles first.
    task automatic post_item(input t_req_item it, input bit silent, output int n_bytes);
        int depth;
        depth   = tx_expect.size();
        n_bytes = predict_frame_bytes(it);
        if (silent) begin
            // the table says no bytes: drop what the predictor queued
            while (tx_expect.size() > depth) begin
                void'(tx_expect.pop_back());
            end
        end
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_action        <= it.action;
        i_slave_id      <= it.slave;
        i_func_select   <= it.fsel;
        i_start_address <= it.addr;
        i_quantity      <= it.qty;
        i_payload       <= it.pay;
        do begin
            @(posedge i_clk);
        end while (o_in_stall !== 1'b0);
    endtask

    // Output side: check each transfer, stall at random, track idle time
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall  <= 1'b0;
            quiet_cycles <= quiet_cycles + 1;
        end else begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                check_wire_byte(o_tx_byte, o_frame_end);
            end
            if ((i_in_valid && o_in_stall === 1'b0) || (o_out_valid === 1'b1 && !i_out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: stop a run that makes no progress
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("watchdog: no transfer for %0d cycles, %0d bytes still expected",
                 QUIET_LIMIT, tx_expect.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_req_item it;
        int        n;
        int        done_items;
        int        pick;
        bit        cut;

        crc_run    = CRC_INIT;
        bytes_owed = 8'd0;
        frame_open = 1'b0;
        word_mode  = 1'b0;

        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_action        <= ACT_HEADER;
        i_slave_id      <= 8'h00;
        i_func_select   <= FSEL_RD_COILS;
        i_start_address <= 16'h0000;
        i_quantity      <= 16'h0000;
        i_payload       <= 16'h0000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int r = 0; r < PLAN_ROWS; r++) begin
            it.action = directed_plan[r].action;
            it.slave  = directed_plan[r].slave;
            it.fsel   = directed_plan[r].fsel;
            it.addr   = directed_plan[r].addr;
            it.qty    = directed_plan[r].qty;
            it.pay    = directed_plan[r].pay;
            post_item(it, directed_plan[r].silent, n);
        end

        // Random sequences; count only items that do something
        done_items = 0;
        while (done_items < RANDOM_ITEMS) begin
            if (done_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 17;
                recv_idle_pct = 69;
            end else if (done_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 69;
                recv_idle_pct = 17;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            it.slave = 8'($urandom_range(255));
            it.addr  = 16'($urandom_range(65535));
            it.qty   = 16'($urandom_range(65535));
            it.pay   = 16'($urandom_range(65535));
            pick     = $urandom_range(99);

            if (pick < 5) begin
                // stray payload: consumed only if a cut frame is still open
                it.action = ACT_PAYLOAD;
                it.fsel   = 3'($urandom_range(7));
                post_item(it, 1'b0, n);
                if (n > 0) done_items++;
            end else if (pick < 9) begin
                it.action = ACT_HEADER;
                it.fsel   = $urandom_range(1) ? FSEL_RSVD_A : FSEL_RSVD_B;
                post_item(it, 1'b0, n);
            end else begin
                it.action = ACT_HEADER;
                it.fsel   = 3'($urandom_range(5));
                // keep most byte counts small; upper quantity bits still toggle
                if ($urandom_range(29) != 0) begin
                    if (it.fsel == FSEL_WR_REGS) begin
                        it.qty = 16'(($urandom_range(511) << 7) | $urandom_range(6));
                    end else if (it.fsel == FSEL_WR_COILS) begin
                        it.qty = 16'(($urandom_range(31) << 11) | $urandom_range(40));
                    end
                end
                post_item(it, 1'b0, n);
                done_items++;

                // feed the open frame; now and then cut it short
                cut = ($urandom_range(99) < 8);
                while (frame_open && !(cut && $urandom_range(3) == 0)) begin
                    it.action = ACT_PAYLOAD;
                    it.slave  = 8'($urandom_range(255));
                    it.fsel   = 3'($urandom_range(7));
                    it.pay    = 16'($urandom_range(65535));
                    post_item(it, 1'b0, n);
                    done_items++;
                end
            end
        end

        // Drain: drop valid, wait for the last byte, then give stragglers time
        i_in_valid <= 1'b0;
        while (tx_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mbrf_pkg.sv
rtl/mbrf_queue.sv
rtl/mbrf_front.sv
rtl/mbrf_back.sv
rtl/modbus_rtu_request_framer.sv
rtl/mbrf_checker.sv
bench/modbus_rtu_request_framer_tb.sv
